[src/cobs_frame_decoder_unit_macros.svh]
// ----------------------------------------------------------------------------
// COBS frame decoder assertion macros
// Shared concurrent assertion wrappers for the decoder's checker.
// ----------------------------------------------------------------------------
`ifndef COBS_FRAME_DECODER_UNIT_MACROS_SVH
`define COBS_FRAME_DECODER_UNIT_MACROS_SVH

// Check a property on every clock edge outside of reset.
`define CFD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("cobs frame decoder: assertion failed");

// Check a property on every clock edge, reset included.
`define CFD_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("cobs frame decoder: reset assertion failed");

`endif

[src/cobsdec_pkg.sv]
// ----------------------------------------------------------------------------
// COBS decoder package
// Shared constants and the request record passed from front to back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cobsdec_pkg;

  localparam int LENGTH_BITS_DEF = 16;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 2;
  localparam int OUT_LEN_W = 16;
  localparam int CAP_W    = 16;

  localparam logic [BYTE_W-1:0] FULL_CODE = 8'hFF;
  localparam logic [CAP_W-1:0]  CAP_RESET = 16'hFFFF;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_TOO_SMALL = 2'd2;

  // One request: an optional data byte followed by an optional status.
  typedef struct packed {
    logic                 has_data;
    logic [BYTE_W-1:0]    data;
    logic                 has_status;
    logic [STATUS_W-1:0]  status;
    logic [OUT_LEN_W-1:0] length;
  } cmd_t;

endpackage

[src/cobs_frame_decoder_unit.sv]
// Results: a byte's request is written into the request queue when the byte
//   is accepted, and the out_ ports show the request at the queue head.
// Throughput: one encoded byte per cycle while in_full is low; the back end
//   hands out one result per cycle while out_pop is high, so a byte with two
//   results costs two pops, absorbed by the QUEUE_DEPTH-entry request queue.
//   Synchronous reset (rst_n low) clears frame state and queue, capacity 65535.
// ----------------------------------------------------------------------------
// COBS frame decoder
// Streaming COBS decoder: one encoded byte in, decoded bytes and a per-frame
// status with the decoded length out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cobs_frame_decoder_unit
  import cobsdec_pkg::*;
#(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // encoded byte input
  input  logic                 in_push,
  output logic                 in_full,
  input  logic [BYTE_W-1:0]    in_byte,
  input  logic                 in_last,
  // decoded result output
  output logic                 out_empty,
  input  logic                 out_pop,
  output logic                 out_kind,
  output logic [BYTE_W-1:0]    out_byte,
  output logic [STATUS_W-1:0]  out_status,
  output logic [OUT_LEN_W-1:0] out_length,
  output logic                 out_run_last,
  // capacity register write
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CAP_W-1:0]     cfg_data
);

  logic [CAP_W-1:0] capacity_r;
  logic             fire;
  logic             q_push, q_pop, q_full, q_empty;
  cmd_t             q_wr, q_rd;

  // Capacity register: always ready; the user must make writes land only while the block is idle (not enforced).
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      capacity_r <= cfg_data;
    end
  end

  // Hold off input whenever the request queue has no room, even for bytes
  // that will not produce a request.
  assign in_full = q_full;
  assign fire    = in_push && !in_full;

  // Front: classify each byte (code or data), update the group state and
  // the length count, and build the request for its results.
  cobsdec_front #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .in_byte (in_byte),
    .in_last (in_last),
    .capacity(capacity_r),
    .push    (q_push),
    .cmd     (q_wr)
  );

  // Queue: decouple the front from a stalled result consumer.
  cobsdec_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wr_cmd(q_wr),
    .full  (q_full),
    .pop   (q_pop),
    .rd_cmd(q_rd),
    .empty (q_empty)
  );

  // Back: drain each request as a data result, a status result, or both,
  // marking the last result of each request.
  cobsdec_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head        (q_rd),
    .head_empty  (q_empty),
    .head_pop    (q_pop),
    .out_empty   (out_empty),
    .out_pop     (out_pop),
    .out_kind    (out_kind),
    .out_byte    (out_byte),
    .out_status  (out_status),
    .out_length  (out_length),
    .out_run_last(out_run_last)
  );

endmodule

[src/cobsdec_front.sv]
// ----------------------------------------------------------------------------
// COBS decoder front end
// Tracks group state per encoded byte and issues requests to the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cobsdec_front
  import cobsdec_pkg::*;
#(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  logic [BYTE_W-1:0] in_byte,
  input  logic              in_last,
  input  logic [CAP_W-1:0]  capacity,
  output logic              push,
  output cmd_t              cmd
);

  localparam int CMP_W = (LENGTH_BITS > CAP_W) ? LENGTH_BITS : CAP_W;
  localparam logic [LENGTH_BITS-1:0] CNT_MAX = {LENGTH_BITS{1'b1}};

  logic                   expect_code_r, expect_code_nxt;
  logic [BYTE_W-1:0]      grp_rem_r, grp_rem_nxt;
  logic                   prev_full_r, prev_full_nxt;
  logic                   first_grp_r, first_grp_nxt;
  logic                   invalid_r, invalid_nxt;
  logic [LENGTH_BITS-1:0] count_r, count_nxt;

  logic [LENGTH_BITS-1:0] cnt_inc;
  logic                   do_count;
  logic                   emit_ok;
  logic [CMP_W-1:0]       cap_x;
  logic [BYTE_W-1:0]      grp_dec;

  assign cap_x   = CMP_W'(capacity);
  assign cnt_inc = (count_r == CNT_MAX) ? count_r : count_r + 1'b1;
  assign emit_ok = !invalid_r && (CMP_W'(cnt_inc) <= cap_x);
  assign grp_dec = (grp_rem_r != '0) ? grp_rem_r - 1'b1 : grp_rem_r;

  always_comb begin
    expect_code_nxt = expect_code_r;
    grp_rem_nxt     = grp_rem_r;
    prev_full_nxt   = prev_full_r;
    first_grp_nxt   = first_grp_r;
    invalid_nxt     = invalid_r;
    do_count        = 1'b0;
    if (expect_code_r) begin
      if (in_byte == '0) begin
        invalid_nxt = 1'b1;
      end else begin
        // a zero goes between groups unless the previous group was full (none before the first)
        do_count        = !first_grp_r && !prev_full_r;
        first_grp_nxt   = 1'b0;
        prev_full_nxt   = (in_byte == FULL_CODE);
        grp_rem_nxt     = in_byte - 1'b1;
        expect_code_nxt = (in_byte == 8'd1);
      end
    end else begin
      do_count        = 1'b1;
      grp_rem_nxt     = grp_dec;
      expect_code_nxt = (grp_dec == '0);
    end
    count_nxt = do_count ? cnt_inc : count_r;
  end

  always_comb begin
    cmd.has_data   = do_count && emit_ok;
    cmd.data       = expect_code_r ? '0 : in_byte;
    cmd.has_status = in_last;
    cmd.length     = OUT_LEN_W'(count_nxt);
    priority if (invalid_nxt || !expect_code_nxt) begin
      cmd.status = ST_INVALID;
    end else if (CMP_W'(count_nxt) > cap_x) begin
      cmd.status = ST_TOO_SMALL;
    end else begin
      cmd.status = ST_OK;
    end
  end

  assign push = fire && (cmd.has_data || in_last);

  always_ff @(posedge clk) begin
    if (!rst_n || (fire && in_last)) begin
      expect_code_r <= 1'b1;
      grp_rem_r     <= '0;
      prev_full_r   <= 1'b0;
      first_grp_r   <= 1'b1;
      invalid_r     <= 1'b0;
      count_r       <= '0;
    end else if (fire) begin
      expect_code_r <= expect_code_nxt;
      grp_rem_r     <= grp_rem_nxt;
      prev_full_r   <= prev_full_nxt;
      first_grp_r   <= first_grp_nxt;
      invalid_r     <= invalid_nxt;
      count_r       <= count_nxt;
    end
  end

endmodule

[src/cobsdec_queue.sv]
// ----------------------------------------------------------------------------
// COBS decoder request queue
// Small register FIFO between front end and back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cobsdec_queue
  import cobsdec_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t wr_cmd,
  output logic full,
  input  logic pop,
  output cmd_t rd_cmd,
  output logic empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  cmd_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_cmd  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

[src/cobsdec_back.sv]
// ----------------------------------------------------------------------------
// COBS decoder back end
// Expands each request into its data and status results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cobsdec_back
  import cobsdec_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  cmd_t                 head,
  input  logic                 head_empty,
  output logic                 head_pop,
  output logic                 out_empty,
  input  logic                 out_pop,
  output logic                 out_kind,
  output logic [BYTE_W-1:0]    out_byte,
  output logic [STATUS_W-1:0]  out_status,
  output logic [OUT_LEN_W-1:0] out_length,
  output logic                 out_run_last
);

  logic data_done_r;
  logic show_data;
  logic take;

  // data goes first; once it is taken the same request shows its status
  assign show_data = head.has_data && !data_done_r;
  assign take      = out_pop && !head_empty;
  assign out_empty = head_empty;
  assign head_pop  = take && !(show_data && head.has_status);

  assign out_kind     = show_data ? KIND_DATA : KIND_STATUS;
  assign out_byte     = show_data ? head.data : '0;
  assign out_status   = show_data ? ST_OK : head.status;
  assign out_length   = show_data ? '0 : head.length;
  assign out_run_last = show_data ? !head.has_status : 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_done_r <= 1'b0;
    end else if (take) begin
      data_done_r <= !head_pop;
    end
  end

endmodule

[src/cobsdec_checker.sv]
// ----------------------------------------------------------------------------
// COBS decoder port checker
// Watches the top level's ports and flags malformed result sequences.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "cobs_frame_decoder_unit_macros.svh"

module cobsdec_checker
  import cobsdec_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_empty,
  input logic                 out_pop,
  input logic                 out_kind,
  input logic [BYTE_W-1:0]    out_byte,
  input logic [STATUS_W-1:0]  out_status,
  input logic [OUT_LEN_W-1:0] out_length,
  input logic                 out_run_last
);

  `CFD_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> out_empty)

  `CFD_ASSERT(a_status_ends_run, clk, rst_n, (!out_empty && out_kind == KIND_STATUS) |-> (out_run_last && out_byte == '0 && out_status != 2'd3))

  `CFD_ASSERT(a_data_clean, clk, rst_n, (!out_empty && out_kind == KIND_DATA) |-> (out_status == ST_OK && out_length == '0))

  `CFD_ASSERT(a_data_then_status, clk, rst_n, (!out_empty && out_pop && out_kind == KIND_DATA && !out_run_last) |=> (!out_empty && out_kind == KIND_STATUS))

  `CFD_ASSERT(a_result_holds, clk, rst_n, (!out_empty && !out_pop) |=> (!out_empty && $stable(out_kind) && $stable(out_byte) && $stable(out_length)))

endmodule

bind cobs_frame_decoder_unit cobsdec_checker u_cobsdec_checker (.*);
